/* rtl/card_number_luhn_classifier_core_macros.svh */
// Assertion helpers used by the checker module.
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_CORE_MACROS_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_CORE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CNLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included.
`define CNLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/cnlc_pkg.sv */
package cnlc_pkg;

  // Input value and converter geometry
  localparam int VALUE_W        = 63;
  localparam int PAD_W          = 64;
  localparam int BITS_PER_STAGE = 4;
  localparam int CONV_STAGES    = PAD_W / BITS_PER_STAGE;
  localparam int BCD_DIGITS     = 19;
  localparam int BCD_W          = 4 * BCD_DIGITS;

  // Longest number accepted, in decimal digits (13..19)
  localparam int MAX_DIGITS     = 19;

  // Result field widths
  localparam int CLASS_W = 2;
  localparam int COUNT_W = 5;
  localparam int PAIR_W  = 7;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_INVALID    = 2'd0,
    CLASS_FIFTEEN_3X = 2'd1,
    CLASS_SIXTEEN_5X = 2'd2,
    CLASS_LEADING_4  = 2'd3
  } card_class_e;

  // One double-dabble step: add 3 to digits of 5 and up, then shift in a bit
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // Digit sum of twice the digit
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [3:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // True when s is a multiple of ten; s stays below 320
  function automatic logic mod10_zero(input logic [7:0] s);
    logic [8:0] r;
    r = {1'b0, s};
    if (r >= 9'd160) r = r - 9'd160;
    if (r >= 9'd80)  r = r - 9'd80;
    if (r >= 9'd40)  r = r - 9'd40;
    if (r >= 9'd20)  r = r - 9'd20;
    if (r >= 9'd10)  r = r - 9'd10;
    return (r == 9'd0);
  endfunction

endpackage

/* rtl/card_number_luhn_classifier_core.sv */
// Channel   Dir  tdata fields (low bit up)                            Size
// s_axis    in   card_value[62:0], zero pad[63]                       64
// m_axis    out  card_class[1:0], luhn_pass[2], digit_count[7:3],     16
//                leading_pair[14:8], zero pad[15]
//
// One word accepted per cycle while m_axis does not stall; each result passes
// through 19 register stages: input register, 16 conversion stages of 4
// double-dabble steps, digit scan stage, check/classify output register.
// Reset clears every valid bit; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline and drops s_axis_tready_o.
module card_number_luhn_classifier_core
  import cnlc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // card_value[62:0], pad[63]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // class, pass, count, pair, pad
);

  // Pipeline advance: everything moves unless the output word is stuck
  logic adv;
  logic out_valid_q;
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Conversion stages: stage 0 is the input register
  logic             cv_valid_q [0:CONV_STAGES];
  logic [PAD_W-1:0] cv_bin_q   [0:CONV_STAGES];
  logic [BCD_W-1:0] cv_bcd_q   [0:CONV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_valid_q[0] <= 1'b0;
    end else if (adv) begin
      cv_valid_q[0] <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cv_bin_q[0] <= {{(PAD_W-VALUE_W){1'b0}}, s_axis_tdata_i[VALUE_W-1:0]};
      cv_bcd_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= CONV_STAGES; k++) begin : g_conv
    logic [PAD_W-1:0] bin_d;
    logic [BCD_W-1:0] bcd_d;

    // Four shift-and-adjust steps, MSB first
    always_comb begin
      bin_d = cv_bin_q[k-1];
      bcd_d = cv_bcd_q[k-1];
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
        bcd_d = dd_step(bcd_d, bin_d[PAD_W-1]);
        bin_d = {bin_d[PAD_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_valid_q[k] <= 1'b0;
      end else if (adv) begin
        cv_valid_q[k] <= cv_valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cv_bin_q[k] <= bin_d;
        cv_bcd_q[k] <= bcd_d;
      end
    end
  end

  // Digit scan: count, leading digits, split Luhn sums
  logic [BCD_W-1:0]   dig;
  logic [COUNT_W-1:0] cnt_d;
  logic [3:0]         first_d, second_d;
  logic [6:0]         even_d, odd_d;

  assign dig = cv_bcd_q[CONV_STAGES];

  always_comb begin
    cnt_d    = COUNT_W'(1);
    first_d  = dig[3:0];
    second_d = 4'd0;
    even_d   = '0;
    odd_d    = '0;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (dig[4*d +: 4] != 4'd0) begin
        cnt_d   = COUNT_W'(d + 1);
        first_d = dig[4*d +: 4];
        if (d > 0) begin
          second_d = dig[4*(d-1) +: 4];
        end
      end
      if ((d % 2) == 1) begin
        odd_d = odd_d + 7'(dbl_digit(dig[4*d +: 4]));
      end else begin
        even_d = even_d + 7'(dig[4*d +: 4]);
      end
    end
  end

  logic               sc_valid_q;
  logic [COUNT_W-1:0] sc_cnt_q;
  logic [3:0]         sc_first_q, sc_second_q;
  logic [6:0]         sc_even_q, sc_odd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
    end else if (adv) begin
      sc_valid_q <= cv_valid_q[CONV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_cnt_q    <= cnt_d;
      sc_first_q  <= first_d;
      sc_second_q <= second_d;
      sc_even_q   <= even_d;
      sc_odd_q    <= odd_d;
    end
  end

  // Luhn check and class decision
  logic [7:0]         sum;
  logic               pass_raw;
  logic [PAIR_W-1:0]  pair_raw;
  logic               too_long;
  card_class_e        class_d;
  logic               pass_d;
  logic [COUNT_W-1:0] count_d;
  logic [PAIR_W-1:0]  pair_d;

  assign sum      = {1'b0, sc_even_q} + {1'b0, sc_odd_q};
  assign pass_raw = mod10_zero(sum);
  assign too_long = (sc_cnt_q > COUNT_W'(MAX_DIGITS));

  always_comb begin
    if (sc_cnt_q >= COUNT_W'(2)) begin
      pair_raw = {sc_first_q, 3'b000} + {2'b00, sc_first_q, 1'b0}
               + {3'b000, sc_second_q};
    end else begin
      pair_raw = {3'b000, sc_first_q};
    end
  end

  always_comb begin
    class_d = CLASS_INVALID;
    pass_d  = pass_raw;
    count_d = sc_cnt_q;
    pair_d  = pair_raw;
    if (too_long) begin
      pass_d  = 1'b0;
      count_d = COUNT_W'(MAX_DIGITS);
      pair_d  = '0;
    end else if (pass_raw) begin
      if (sc_cnt_q == COUNT_W'(15) &&
          (pair_raw == PAIR_W'(34) || pair_raw == PAIR_W'(37))) begin
        class_d = CLASS_FIFTEEN_3X;
      end else if (sc_cnt_q == COUNT_W'(16) &&
                   pair_raw >= PAIR_W'(51) && pair_raw <= PAIR_W'(55)) begin
        class_d = CLASS_SIXTEEN_5X;
      end else if ((sc_cnt_q == COUNT_W'(16) || sc_cnt_q == COUNT_W'(13)) &&
                   sc_first_q == 4'd4) begin
        class_d = CLASS_LEADING_4;
      end
    end
  end

  // Output register
  card_class_e        class_q;
  logic               pass_q;
  logic [COUNT_W-1:0] count_q;
  logic [PAIR_W-1:0]  pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sc_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      class_q <= class_d;
      pass_q  <= pass_d;
      count_q <= count_d;
      pair_q  <= pair_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, pair_q, count_q, pass_q, class_q};

endmodule

/* rtl/cnlc_checker.sv */
`include "card_number_luhn_classifier_core_macros.svh"

module cnlc_checker
  import cnlc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // No word on the output while in reset
  `CNLC_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid_o, "valid during reset")

  // A stalled output word holds
  `CNLC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "output word changed under stall")

  // Input is taken exactly when the output is free or drains
  `CNLC_ASSERT(a_ready_rule, clk_i, rst_ni, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i), "ready does not follow output stall")

  // A card class implies a passing Luhn check and a known length
  `CNLC_ASSERT(a_class_pass, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[1:0] != CLASS_INVALID |-> m_axis_tdata_o[2] && (m_axis_tdata_o[7:3] == 5'd13 || m_axis_tdata_o[7:3] == 5'd15 || m_axis_tdata_o[7:3] == 5'd16), "class without valid check or length")

  // Digit count in range, pair under 100, pad bit clear
  `CNLC_ASSERT(a_fields_range, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[7:3] != 5'd0 && m_axis_tdata_o[7:3] <= 5'(MAX_DIGITS) && m_axis_tdata_o[14:8] <= 7'd99 && !m_axis_tdata_o[15], "result field out of range")

endmodule

bind card_number_luhn_classifier_core cnlc_checker u_cnlc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
